// ----- sv/textured_wall_column_span_unit_defines.svh -----
// assertion macros shared by the wall column span checker
`ifndef TEXTURED_WALL_COLUMN_SPAN_UNIT_DEFINES_SVH
`define TEXTURED_WALL_COLUMN_SPAN_UNIT_DEFINES_SVH

// same-cycle implication under the checker clock and reset
`define TWCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under the checker clock and reset
`define TWCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/twcs_pkg.sv -----
// types and constants of the textured wall column span unit
`default_nettype none

package twcs_pkg;

    // default geometry
    localparam int unsigned SCREEN_H_DEF  = 1024;
    localparam int unsigned FRAC_BITS_DEF = 16;

    localparam int unsigned BYTES_PER_PIXEL = 4;

    // field widths
    localparam int unsigned COLUMN_W = 10;
    localparam int unsigned SIDE_W   = 2;
    localparam int unsigned POS_W    = 24;
    localparam int unsigned DIR_W    = 18;
    localparam int unsigned ROW_W    = 11;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned FACE_W   = 2;
    localparam int unsigned OFS_W    = 24;
    localparam int unsigned TPOS_W   = 32;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned TW_W       = 11;
    localparam int unsigned HL2_W      = 4;
    localparam int unsigned PITCH_W    = 15;

    localparam logic [TW_W-1:0]    TEX_WIDTH_RST  = 11'd64;
    localparam logic [HL2_W-1:0]   TEX_HL2_RST    = 4'd6;
    localparam logic [PITCH_W-1:0] TEX_PITCH_RST  = 15'd256;
    localparam logic [PITCH_W-1:0] FRAME_PITCH_RST = 15'd4096;
    localparam logic [TW_W-1:0]    TEX_WIDTH_MAX  = 11'd1024;
    localparam logic [HL2_W-1:0]   TEX_HL2_MAX    = 4'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXTURE_WIDTH = 2'd0,
        CFG_TEXTURE_HL2   = 2'd1,
        CFG_TEXTURE_PITCH = 2'd2,
        CFG_FRAME_PITCH   = 2'd3
    } t_cfg_reg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [SIDE_W-1:0] HIT_VERT = 2'd0;
    localparam logic [SIDE_W-1:0] HIT_HORZ = 2'd1;

    localparam logic [FACE_W-1:0] FACE_NORTH = 2'd0;
    localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd1;
    localparam logic [FACE_W-1:0] FACE_EAST  = 2'd2;
    localparam logic [FACE_W-1:0] FACE_WEST  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAC,
        S_COL,
        S_DIV,
        S_POS
    } t_state;

endpackage

`default_nettype wire

// ----- sv/textured_wall_column_span_unit.sv -----
// textured wall column span unit: texture column, step and per-row offsets
//
//  channel   dir  handshake                  payload
//  in        in   i_in_valid / o_in_ready    i_command .. i_span_length
//  out       out  o_out_valid / i_out_ready  o_face o_texel_offset o_pixel_offset o_last
//  cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// a start with a hit takes the transfer, then runs in the shared adder the hit
// fraction (S_FRAC), the texture column (S_COL), the step divide (S_DIV) and the
// start position (S_POS), in that order; a start with no hit or an empty span
// stays in S_IDLE
// a pixel tick on an active span loads the output register; the next transfer
// is taken as soon as that register is empty or drains in the same cycle
// reset restores the register defaults and drops any span; cfg is always ready
`default_nettype none

module textured_wall_column_span_unit
    import twcs_pkg::*;
#(
    parameter int unsigned SCREEN_H  = SCREEN_H_DEF,
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_command,
    input  wire logic [COLUMN_W-1:0]          i_column,
    input  wire logic [SIDE_W-1:0]            i_hit_side,
    input  wire logic [POS_W-1:0]             i_pos_x,
    input  wire logic [POS_W-1:0]             i_pos_y,
    input  wire logic signed [DIR_W-1:0]      i_dir_x,
    input  wire logic signed [DIR_W-1:0]      i_dir_y,
    input  wire logic [POS_W-1:0]             i_wall_distance,
    input  wire logic [ROW_W-1:0]             i_span_start,
    input  wire logic [ROW_W-1:0]             i_span_end,
    input  wire logic [LEN_W-1:0]             i_span_length,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [FACE_W-1:0]                 o_face,
    output logic [OFS_W-1:0]                  o_texel_offset,
    output logic [OFS_W-1:0]                  o_pixel_offset,
    output logic                              o_last,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int unsigned AW    = (2*FRAC_BITS + 11 > 32) ? 2*FRAC_BITS + 11 : 32;
    localparam int unsigned QW    = FRAC_BITS + 11;
    localparam int unsigned CNT_W = $clog2(QW);
    localparam logic [DIR_W-1:0] HALF_H = DIR_W'(SCREEN_H / 2);

    // control
    t_state                r_state, n_state;
    logic                  r_active, n_active;
    logic                  r_out_valid, n_out_valid;
    logic [TW_W-1:0]       r_tex_width;
    logic [HL2_W-1:0]      r_tex_hl2;
    logic [PITCH_W-1:0]    r_tex_pitch;
    logic [PITCH_W-1:0]    r_frame_pitch;

    // shared unit and span state
    logic [AW-1:0]         r_acc, n_acc;
    logic [AW-1:0]         r_mcand, n_mcand;
    logic [DIR_W-1:0]      r_mplier, n_mplier;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [LEN_W-1:0]      r_rem, n_rem;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [DIR_W-1:0]      r_off, n_off;
    logic                  r_mirror, n_mirror;
    logic [FACE_W-1:0]     r_face, n_face;
    logic [COLUMN_W-1:0]   r_column, n_column;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [ROW_W-1:0]      r_end, n_end;
    logic [TPOS_W-1:0]     r_tex_pos, n_tex_pos;
    logic [TPOS_W-1:0]     r_tex_step, n_tex_step;
    logic [COLUMN_W-1:0]   r_tex_column, n_tex_column;

    // output register
    logic [FACE_W-1:0]     r_out_face, n_out_face;
    logic [OFS_W-1:0]      r_out_texel, n_out_texel;
    logic [OFS_W-1:0]      r_out_pixel, n_out_pixel;
    logic                  r_out_last, n_out_last;

    logic                  w_in_fire;
    logic [TW_W-1:0]       w_width_eff;
    logic [HL2_W-1:0]      w_hl2_eff;
    logic [LEN_W-1:0]      w_len_eff;
    logic [AW-1:0]         w_add_a, w_add_b, w_sum, w_step_val;
    logic                  w_add_sub;
    logic                  w_nbit;
    logic [LEN_W:0]        w_trial;
    logic                  w_geq;
    logic [TW_W-1:0]       w_col, w_col_mir;
    logic [COLUMN_W-1:0]   w_row_mask;
    logic [COLUMN_W-1:0]   w_tex_row;
    logic [TPOS_W+COLUMN_W-1:0] w_pos_ext;
    logic [ROW_W:0]        w_row_inc;
    logic                  w_is_last;
    logic [OFS_W:0]        w_texel_prod;
    logic [OFS_W+1:0]      w_pixel_prod;
    logic                  w_dx_pos, w_dy_pos;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire   = i_in_valid && o_in_ready;

    assign o_out_valid    = r_out_valid;
    assign o_face         = r_out_face;
    assign o_texel_offset = r_out_texel;
    assign o_pixel_offset = r_out_pixel;
    assign o_last         = r_out_last;

    assign w_width_eff = (r_tex_width == '0) ? TW_W'(1) :
                         (r_tex_width > TEX_WIDTH_MAX) ? TEX_WIDTH_MAX : r_tex_width;
    assign w_hl2_eff   = (r_tex_hl2 > TEX_HL2_MAX) ? TEX_HL2_MAX : r_tex_hl2;
    assign w_len_eff   = (i_span_length == '0) ? LEN_W'(1) : i_span_length;

    assign w_dx_pos = !i_dir_x[DIR_W-1] && (i_dir_x != '0);
    assign w_dy_pos = !i_dir_y[DIR_W-1] && (i_dir_y != '0);

    // restoring divide of a power of two: one numerator bit enters per step
    assign w_nbit  = (r_cnt == (CNT_W'(w_hl2_eff) + CNT_W'(FRAC_BITS)));
    assign w_trial = {r_rem, w_nbit};

    // the shared adder
    always_comb begin
        w_add_a   = r_acc;
        w_add_b   = r_mcand;
        w_add_sub = 1'b0;
        unique case (r_state) inside
            S_IDLE: begin
                w_add_a = AW'(r_tex_pos);
                w_add_b = AW'(r_tex_step);
            end
            S_FRAC, S_POS: begin
                // top bit of the signed multiplier weighs negative
                w_add_sub = (r_cnt == '0);
            end
            S_COL: begin
                w_add_sub = 1'b0;
            end
            S_DIV: begin
                w_add_a   = AW'(w_trial);
                w_add_b   = AW'(r_len);
                w_add_sub = 1'b1;
            end
        endcase
    end

    assign w_sum      = w_add_a + (w_add_sub ? ~w_add_b : w_add_b) + AW'(w_add_sub);
    assign w_step_val = r_mplier[0] ? w_sum : r_acc;
    assign w_geq      = !w_sum[AW-1];

    assign w_col     = w_step_val[2*FRAC_BITS +: TW_W];
    assign w_col_mir = w_width_eff - w_col - TW_W'(1);

    // tick datapath
    assign w_pos_ext    = {COLUMN_W'(0), r_tex_pos};
    assign w_row_mask   = ~(COLUMN_W'({COLUMN_W{1'b1}}) << w_hl2_eff);
    assign w_tex_row    = w_pos_ext[FRAC_BITS +: COLUMN_W] & w_row_mask;
    assign w_texel_prod = (OFS_W+1)'(w_tex_row) * (OFS_W+1)'(r_tex_pitch);
    assign w_pixel_prod = (OFS_W+2)'(r_row) * (OFS_W+2)'(r_frame_pitch);
    assign w_row_inc    = {1'b0, r_row} + (ROW_W+1)'(1);
    assign w_is_last    = w_row_inc >= {1'b0, r_end};

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_out_valid  = r_out_valid;
        n_acc        = r_acc;
        n_mcand      = r_mcand;
        n_mplier     = r_mplier;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_len        = r_len;
        n_off        = r_off;
        n_mirror     = r_mirror;
        n_face       = r_face;
        n_column     = r_column;
        n_row        = r_row;
        n_end        = r_end;
        n_tex_pos    = r_tex_pos;
        n_tex_step   = r_tex_step;
        n_tex_column = r_tex_column;
        n_out_face   = r_out_face;
        n_out_texel  = r_out_texel;
        n_out_pixel  = r_out_pixel;
        n_out_last   = r_out_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_command == CMD_START) begin
                        n_active = 1'b0;
                        if (((i_hit_side == HIT_VERT) || (i_hit_side == HIT_HORZ)) &&
                            (i_span_start < i_span_end)) begin
                            if (i_hit_side == HIT_VERT) begin
                                n_face   = w_dx_pos ? FACE_WEST : FACE_EAST;
                                n_mirror = w_dx_pos;
                                n_acc    = AW'(i_pos_y[FRAC_BITS-1:0]) << FRAC_BITS;
                                n_mplier = i_dir_y;
                            end else begin
                                n_face   = w_dy_pos ? FACE_NORTH : FACE_SOUTH;
                                n_mirror = i_dir_y[DIR_W-1];
                                n_acc    = AW'(i_pos_x[FRAC_BITS-1:0]) << FRAC_BITS;
                                n_mplier = i_dir_x;
                            end
                            n_mcand  = AW'(i_wall_distance);
                            n_cnt    = CNT_W'(DIR_W - 1);
                            n_len    = w_len_eff;
                            n_off    = DIR_W'(i_span_start) + DIR_W'(w_len_eff[LEN_W-1:1])
                                       - HALF_H;
                            n_column = i_column;
                            n_row    = i_span_start;
                            n_end    = i_span_end;
                            n_state  = S_FRAC;
                        end
                    end else if (r_active) begin
                        n_out_valid = 1'b1;
                        n_out_face  = r_face;
                        n_out_texel = w_texel_prod[OFS_W-1:0] +
                                      OFS_W'(r_tex_column) * OFS_W'(BYTES_PER_PIXEL);
                        n_out_pixel = w_pixel_prod[OFS_W-1:0] +
                                      OFS_W'(r_column) * OFS_W'(BYTES_PER_PIXEL);
                        n_out_last  = w_is_last;
                        n_tex_pos   = w_sum[TPOS_W-1:0];
                        n_row       = w_row_inc[ROW_W-1:0];
                        if (w_is_last) begin
                            n_active = 1'b0;
                        end
                    end
                end
            end
            S_FRAC: begin
                n_acc    = w_step_val;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    // hit fraction becomes the multiplicand for the width
                    n_acc    = '0;
                    n_mcand  = AW'(w_step_val[2*FRAC_BITS-1:0]);
                    n_mplier = DIR_W'(w_width_eff);
                    n_cnt    = CNT_W'(TW_W - 1);
                    n_state  = S_COL;
                end
            end
            S_COL: begin
                n_acc    = w_step_val;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_tex_column = r_mirror ? w_col_mir[COLUMN_W-1:0] : w_col[COLUMN_W-1:0];
                    n_acc        = '0;
                    n_rem        = '0;
                    n_cnt        = CNT_W'(QW - 1);
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                n_acc = {r_acc[AW-2:0], w_geq};
                n_rem = w_geq ? w_sum[LEN_W-1:0] : w_trial[LEN_W-1:0];
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_tex_step = {r_acc[TPOS_W-2:0], w_geq};
                    n_acc      = '0;
                    n_mcand    = AW'({r_acc[TPOS_W-2:0], w_geq});
                    n_mplier   = r_off;
                    n_cnt      = CNT_W'(DIR_W - 1);
                    n_state    = S_POS;
                end
            end
            S_POS: begin
                n_acc    = w_step_val;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_tex_pos = w_step_val[TPOS_W-1:0];
                    n_active  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_tex_width   <= TEX_WIDTH_RST;
            r_tex_hl2     <= TEX_HL2_RST;
            r_tex_pitch   <= TEX_PITCH_RST;
            r_frame_pitch <= FRAME_PITCH_RST;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_TEXTURE_WIDTH: r_tex_width   <= i_cfg_data[TW_W-1:0];
                    CFG_TEXTURE_HL2:   r_tex_hl2     <= i_cfg_data[HL2_W-1:0];
                    CFG_TEXTURE_PITCH: r_tex_pitch   <= i_cfg_data[PITCH_W-1:0];
                    CFG_FRAME_PITCH:   r_frame_pitch <= i_cfg_data[PITCH_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_mcand      <= n_mcand;
        r_mplier     <= n_mplier;
        r_cnt        <= n_cnt;
        r_rem        <= n_rem;
        r_len        <= n_len;
        r_off        <= n_off;
        r_mirror     <= n_mirror;
        r_face       <= n_face;
        r_column     <= n_column;
        r_row        <= n_row;
        r_end        <= n_end;
        r_tex_pos    <= n_tex_pos;
        r_tex_step   <= n_tex_step;
        r_tex_column <= n_tex_column;
        r_out_face   <= n_out_face;
        r_out_texel  <= n_out_texel;
        r_out_pixel  <= n_out_pixel;
        r_out_last   <= n_out_last;
    end

endmodule

`default_nettype wire

// ----- sv/twcs_checker.sv -----
// port checker of the textured wall column span unit and its bind
`default_nettype none
`include "textured_wall_column_span_unit_defines.svh"

module twcs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_command,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_face,
    input wire logic [23:0] i_texel_offset,
    input wire logic [23:0] i_pixel_offset,
    input wire logic        i_last
);

    // a stalled result stays put
    `TWCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `TWCS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_face) && $stable(i_texel_offset) && $stable(i_pixel_offset) && $stable(i_last), "result changed while stalled")
    // input only taken when the output register can hold a new result
    `TWCS_ASSERT_SAME(a_ready_room, i_clk, i_rst_n, i_in_ready, !i_out_valid || i_out_ready, "input ready with output register full")
    // a start transfer never yields a result
    `TWCS_ASSERT_NEXT(a_start_silent, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_command, !$rose(i_out_valid), "result after a start transfer")

endmodule

bind textured_wall_column_span_unit twcs_checker u_twcs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .i_in_ready     (o_in_ready),
    .i_command      (i_command),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_face         (o_face),
    .i_texel_offset (o_texel_offset),
    .i_pixel_offset (o_pixel_offset),
    .i_last         (o_last)
);

`default_nettype wire
